// ----- design/srsf_pkg.sv -----
// Shared types, codes and constants of the sparse row scale factor generator.
// No dependencies; every other design file refers to this package by scoped names.
package srsf_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int COLUMN_BITS = 16;
   localparam int ROW_BITS    = 16;
   localparam int COUNT_BITS  = 17;
   localparam int SUM_BITS    = 64;
   localparam int DEF_MAX_ROWS = 65536;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [31:0] FX_ONE    = 32'h0001_0000;
   localparam logic [31:0] FX_ZERO   = 32'h0000_0000;
   localparam logic [31:0] FX_MAXPOS = 32'h7FFF_FFFF;
   localparam logic [31:0] FX_MINNEG = 32'h8000_0000;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_NORM   = 2'd1;
   localparam logic [1:0] KIND_DIAG   = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [1:0] REG_SCALE_KIND   = 2'd0;
   localparam logic [1:0] REG_BOTH_SIDES   = 2'd1;
   localparam logic [1:0] REG_ROW_COUNT    = 2'd2;
   localparam logic [1:0] REG_COLUMN_COUNT = 2'd3;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_ZERO    = 3'd1,
      ST_NEG     = 3'd2,
      ST_NOSCALE = 3'd3,
      ST_SAT     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_DIV,
      B_SQRT,
      B_DONE
   } back_state_type;

   typedef struct packed {
      logic [1:0]            scale_kind;
      logic                  both_sides;
      logic [COUNT_BITS-1:0] row_count;
      logic [COUNT_BITS-1:0] column_count;
   } cfg_type;

   typedef struct packed {
      logic [ROW_BITS-1:0]   row_index;
      logic [SUM_BITS-1:0]   square_sum;
      logic [VALUE_BITS-1:0] diagonal;
      logic                  last_row;
   } job_type;

endpackage

// ----- design/srsf_queue.sv -----
// Short first-in first-out queue of row jobs between the front and back parts.
// Depends on srsf_pkg for the job type and depth.
module srsf_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  srsf_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output srsf_pkg::job_type pop_job,
   output logic             empty
);

   localparam int PW = (srsf_pkg::QUEUE_DEPTH > 1) ? $clog2(srsf_pkg::QUEUE_DEPTH) : 1;

   srsf_pkg::job_type   slot_ff [srsf_pkg::QUEUE_DEPTH];
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PW:0]         count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == (PW+1)'(srsf_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(srsf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(srsf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- design/srsf_front.sv -----
// Front part: takes nonzeros, squares and accumulates them, tracks the diagonal and rows.
// Depends on srsf_pkg; hands one job per row end to srsf_queue.
module srsf_front #(
   parameter int MAX_ROWS = srsf_pkg::DEF_MAX_ROWS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  srsf_pkg::cfg_type                   cfg,
   input  logic                                push,
   output logic                                full,
   input  logic [srsf_pkg::VALUE_BITS-1:0]     entry_value,
   input  logic [srsf_pkg::COLUMN_BITS-1:0]    entry_column,
   input  logic                                has_entry,
   input  logic                                row_end,
   output logic                                q_push,
   output srsf_pkg::job_type                   q_job,
   input  logic                                q_full
);

   localparam int CW = $clog2(MAX_ROWS);
   localparam int VB = srsf_pkg::VALUE_BITS;

   logic                              s1_valid_ff, s1_valid_in;
   logic [VB-1:0]                     s1_mag_ff;
   logic [VB-1:0]                     s1_value_ff;
   logic [srsf_pkg::COLUMN_BITS-1:0]  s1_column_ff;
   logic                              s1_has_ff;
   logic                              s1_end_ff;

   logic                              s2_valid_ff, s2_valid_in;
   logic [srsf_pkg::SUM_BITS-1:0]     s2_square_ff;
   logic [VB-1:0]                     s2_value_ff;
   logic [srsf_pkg::COLUMN_BITS-1:0]  s2_column_ff;
   logic                              s2_has_ff;
   logic                              s2_end_ff;

   logic [srsf_pkg::SUM_BITS-1:0]     sum_ff, sum_in;
   logic [VB-1:0]                     diag_ff, diag_in;
   logic [CW-1:0]                     row_ff, row_in;

   logic                              accept, fire2, free2, move1;
   logic [VB-1:0]                     in_mag;
   logic [srsf_pkg::SUM_BITS:0]       sum_wide;
   logic [srsf_pkg::SUM_BITS-1:0]     sum_new;
   logic [VB-1:0]                     diag_new;
   logic [31:0]                       row_next;
   logic                              last_row;

   assign in_mag = entry_value[VB-1] ? (~entry_value) + 1'b1 : entry_value;

   assign fire2  = s2_valid_ff && !(s2_end_ff && q_full);
   assign free2  = !s2_valid_ff || fire2;
   assign move1  = s1_valid_ff && free2;
   assign full   = s1_valid_ff && !move1;
   assign accept = push && !full;

   assign sum_wide = {1'b0, sum_ff} + {1'b0, s2_square_ff};
   assign sum_new  = sum_wide[srsf_pkg::SUM_BITS] ? '1 : sum_wide[srsf_pkg::SUM_BITS-1:0];
   assign diag_new = (s2_has_ff && (32'(s2_column_ff) == 32'(row_ff))) ? s2_value_ff : diag_ff;
   assign row_next = 32'(row_ff) + 32'd1;
   assign last_row = (cfg.row_count != '0) && (row_next == 32'(cfg.row_count));

   assign q_push             = fire2 && s2_end_ff;
   assign q_job.row_index    = 16'(row_ff);
   assign q_job.square_sum   = sum_new;
   assign q_job.diagonal     = diag_new;
   assign q_job.last_row     = last_row;

   always_comb begin
      s1_valid_in = (s1_valid_ff && !move1) || accept;
      s2_valid_in = (s2_valid_ff && !fire2) || move1;
      sum_in      = sum_ff;
      diag_in     = diag_ff;
      row_in      = row_ff;
      if (fire2) begin
         if (s2_end_ff) begin
            sum_in  = '0;
            diag_in = '0;
            row_in  = (last_row || (row_next >= 32'(MAX_ROWS))) ? '0 : CW'(row_next);
         end else begin
            sum_in  = sum_new;
            diag_in = diag_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         sum_ff      <= '0;
         diag_ff     <= '0;
         row_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         sum_ff      <= sum_in;
         diag_ff     <= diag_in;
         row_ff      <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mag_ff    <= in_mag;
         s1_value_ff  <= entry_value;
         s1_column_ff <= entry_column;
         s1_has_ff    <= has_entry;
         s1_end_ff    <= row_end;
      end
      if (move1) begin
         s2_square_ff <= s1_has_ff ? {{(srsf_pkg::SUM_BITS-VB){1'b0}}, s1_mag_ff}
                                     * {{(srsf_pkg::SUM_BITS-VB){1'b0}}, s1_mag_ff}
                                   : '0;
         s2_value_ff  <= s1_value_ff;
         s2_column_ff <= s1_column_ff;
         s2_has_ff    <= s1_has_ff;
         s2_end_ff    <= s1_end_ff;
      end
   end

endmodule

// ----- design/srsf_back.sv -----
// Back part: turns one row job into a factor with a shared restoring divider and root unit.
// Depends on srsf_pkg; takes jobs from srsf_queue and holds the result in an output register.
module srsf_back (
   input  logic                          clock,
   input  logic                          reset,
   input  srsf_pkg::cfg_type             cfg,
   input  logic                          q_empty,
   output logic                          q_pop,
   input  srsf_pkg::job_type             q_job,
   output logic                          empty,
   input  logic                          pop,
   output logic [srsf_pkg::ROW_BITS-1:0] row_index,
   output logic [31:0]                   factor,
   output logic [2:0]                    status,
   output logic                          last_row
);

   typedef struct packed {
      logic [31:0] factor;
      logic [2:0]  status;
   } result_type;

   function automatic result_type clamp(input logic [64:0] v, input logic neg);
      result_type r;
      r.status = srsf_pkg::ST_OK;
      if (neg) begin
         if (v > 65'(srsf_pkg::FX_MINNEG)) begin
            r.status = srsf_pkg::ST_SAT;
            r.factor = srsf_pkg::FX_MINNEG;
         end else begin
            r.factor = 32'd0 - v[31:0];
         end
      end else if (v > 65'(srsf_pkg::FX_MAXPOS)) begin
         r.status = srsf_pkg::ST_SAT;
         r.factor = srsf_pkg::FX_MAXPOS;
      end else begin
         r.factor = v[31:0];
      end
      return r;
   endfunction

   srsf_pkg::back_state_type state_ff, state_in;

   logic [64:0] num_ff, num_in;
   logic [63:0] den_ff, den_in;
   logic [63:0] rem_ff, rem_in;
   logic [64:0] quo_ff, quo_in;
   logic [63:0] op_ff, op_in;
   logic [63:0] root_ff, root_in;
   logic [63:0] bit_ff, bit_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        sqrt_ff, sqrt_in;
   logic        neg_ff, neg_in;
   logic [srsf_pkg::ROW_BITS-1:0] row_ff, row_in;
   logic        last_ff, last_in;
   result_type  res_ff, res_in;

   logic        out_valid_ff, out_valid_in;
   logic [srsf_pkg::ROW_BITS-1:0] out_row_ff, out_row_in;
   result_type  out_res_ff, out_res_in;
   logic        out_last_ff, out_last_in;

   logic        job_direct, job_sqrt, job_neg;
   logic [64:0] job_num;
   logic [63:0] job_den;
   result_type  job_res;
   logic        d_neg;
   logic [31:0] d_mag;

   logic [64:0] trial, diff;
   logic        div_ge;
   logic [64:0] quo_next;
   logic [63:0] rem_next;
   logic [63:0] sq_sum;
   logic        sq_ge;
   logic [63:0] root_next;
   logic        out_free, step_last;

   assign d_neg = q_job.diagonal[31];
   assign d_mag = d_neg ? (~q_job.diagonal) + 1'b1 : q_job.diagonal;

   always_comb begin
      job_direct     = 1'b0;
      job_sqrt       = 1'b0;
      job_neg        = 1'b0;
      job_num        = '0;
      job_den        = '0;
      job_res.factor = srsf_pkg::FX_ZERO;
      job_res.status = srsf_pkg::ST_OK;
      if ((cfg.scale_kind != srsf_pkg::KIND_NORM && cfg.scale_kind != srsf_pkg::KIND_DIAG)
          || cfg.row_count != cfg.column_count) begin
         job_direct     = 1'b1;
         job_res.factor = srsf_pkg::FX_ONE;
         job_res.status = srsf_pkg::ST_NOSCALE;
      end else if (cfg.scale_kind == srsf_pkg::KIND_NORM) begin
         if (q_job.square_sum == '0) begin
            job_direct     = 1'b1;
            job_res.factor = srsf_pkg::FX_MAXPOS;
            job_res.status = srsf_pkg::ST_ZERO;
         end else if (cfg.both_sides) begin
            job_num = 65'd1 << 48;
            job_den = q_job.square_sum;
         end else if (q_job.square_sum == 64'd1) begin
            job_direct     = 1'b1;
            job_res.factor = srsf_pkg::FX_MAXPOS;
            job_res.status = srsf_pkg::ST_SAT;
         end else begin
            job_num  = 65'd1 << 64;
            job_den  = q_job.square_sum;
            job_sqrt = 1'b1;
         end
      end else begin
         if (d_mag == '0) begin
            job_direct     = 1'b1;
            job_res.factor = srsf_pkg::FX_MAXPOS;
            job_res.status = srsf_pkg::ST_ZERO;
         end else if (cfg.both_sides) begin
            if (d_neg) begin
               job_direct     = 1'b1;
               job_res.factor = srsf_pkg::FX_ZERO;
               job_res.status = srsf_pkg::ST_NEG;
            end else begin
               job_num  = 65'd1 << 48;
               job_den  = 64'(d_mag);
               job_sqrt = 1'b1;
            end
         end else begin
            job_num = 65'd1 << 32;
            job_den = 64'(d_mag);
            job_neg = d_neg;
         end
      end
   end

   assign trial     = {rem_ff, num_ff[64]};
   assign diff      = trial - {1'b0, den_ff};
   assign div_ge    = (trial >= {1'b0, den_ff});
   assign rem_next  = div_ge ? diff[63:0] : trial[63:0];
   assign quo_next  = {quo_ff[63:0], div_ge};
   assign sq_sum    = root_ff + bit_ff;
   assign sq_ge     = (op_ff >= sq_sum);
   assign root_next = sq_ge ? (root_ff >> 1) + bit_ff : (root_ff >> 1);
   assign step_last = (cnt_ff == '0);
   assign out_free  = !out_valid_ff || pop;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srsf_pkg::B_IDLE: begin
            if (!q_empty) begin
               state_in = job_direct ? srsf_pkg::B_DONE : srsf_pkg::B_DIV;
            end
         end
         srsf_pkg::B_DIV: begin
            if (step_last) begin
               state_in = sqrt_ff ? srsf_pkg::B_SQRT : srsf_pkg::B_DONE;
            end
         end
         srsf_pkg::B_SQRT: begin
            if (step_last) begin
               state_in = srsf_pkg::B_DONE;
            end
         end
         srsf_pkg::B_DONE: begin
            if (out_free) begin
               state_in = srsf_pkg::B_IDLE;
            end
         end
         default: state_in = srsf_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      q_pop = 1'b0;
      case (state_ff)
         srsf_pkg::B_IDLE: q_pop = !q_empty;
         default:          q_pop = 1'b0;
      endcase
   end

   always_comb begin
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      op_in        = op_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      cnt_in       = cnt_ff;
      sqrt_in      = sqrt_ff;
      neg_in       = neg_ff;
      row_in       = row_ff;
      last_in      = last_ff;
      res_in       = res_ff;
      out_valid_in = out_valid_ff && !pop;
      out_row_in   = out_row_ff;
      out_res_in   = out_res_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         srsf_pkg::B_IDLE: begin
            if (!q_empty) begin
               num_in  = job_num;
               den_in  = job_den;
               rem_in  = '0;
               quo_in  = '0;
               cnt_in  = 7'd64;
               sqrt_in = job_sqrt;
               neg_in  = job_neg;
               row_in  = q_job.row_index;
               last_in = q_job.last_row;
               res_in  = job_res;
            end
         end
         srsf_pkg::B_DIV: begin
            num_in = num_ff << 1;
            rem_in = rem_next;
            quo_in = quo_next;
            cnt_in = cnt_ff - 1'b1;
            if (step_last) begin
               if (sqrt_ff) begin
                  op_in   = quo_next[63:0];
                  root_in = '0;
                  bit_in  = 64'd1 << 62;
                  cnt_in  = 7'd31;
               end else begin
                  res_in = clamp(quo_next, neg_ff);
               end
            end
         end
         srsf_pkg::B_SQRT: begin
            op_in   = sq_ge ? op_ff - sq_sum : op_ff;
            root_in = root_next;
            bit_in  = bit_ff >> 2;
            cnt_in  = cnt_ff - 1'b1;
            if (step_last) begin
               res_in = clamp({1'b0, root_next}, 1'b0);
            end
         end
         srsf_pkg::B_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_row_in   = row_ff;
               out_res_in   = res_ff;
               out_last_in  = last_ff;
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srsf_pkg::B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff      <= num_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      op_ff       <= op_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      cnt_ff      <= cnt_in;
      sqrt_ff     <= sqrt_in;
      neg_ff      <= neg_in;
      row_ff      <= row_in;
      last_ff     <= last_in;
      res_ff      <= res_in;
      out_row_ff  <= out_row_in;
      out_res_ff  <= out_res_in;
      out_last_ff <= out_last_in;
   end

   assign empty     = !out_valid_ff;
   assign row_index = out_row_ff;
   assign factor    = out_res_ff.factor;
   assign status    = out_res_ff.status;
   assign last_row  = out_last_ff;

endmodule

// ----- design/sparse_row_scale_factor_gen_core.sv -----
// Top level of the sparse row scale factor generator: register port, front, queue, back.
// Depends on srsf_pkg, srsf_front, srsf_queue and srsf_back.
//
//   Port group   Handshake          Moves
//   req_*        push / full        one matrix entry or empty-row mark per request
//   rsp_*        pop / empty        one row factor per request
//   p*           psel/penable/...   register writes and reads, always ready
//
// The front takes one request every cycle when unstalled; a square costs one registered multiply.
// A row end passes front registers s1 and s2 into the queue; the back then uses the divider alone
// for a plain reciprocal, the divider followed by a square root, or neither for a settled case.
// A two-entry queue lets the front run ahead while the back works on earlier rows.
// Reset clears all control state and loads the register defaults; no memory needs clearing.
module sparse_row_scale_factor_gen_core #(
   parameter int MAX_ROWS = srsf_pkg::DEF_MAX_ROWS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [srsf_pkg::VALUE_BITS-1:0]     req_entry_value,
   input  logic [srsf_pkg::COLUMN_BITS-1:0]    req_entry_column,
   input  logic                                req_has_entry,
   input  logic                                req_row_end,
   output logic                                empty,
   input  logic                                pop,
   output logic [srsf_pkg::ROW_BITS-1:0]       rsp_row_index,
   output logic [31:0]                         rsp_factor,
   output logic [2:0]                          rsp_status,
   output logic                                rsp_last_row,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [3:0]                          paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   srsf_pkg::cfg_type cfg_ff, cfg_in;
   srsf_pkg::job_type push_job, pop_job;
   logic              q_push, q_full, q_pop, q_empty;
   logic              csr_write;
   logic [1:0]        csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            srsf_pkg::REG_SCALE_KIND:   cfg_in.scale_kind   = pwdata[1:0];
            srsf_pkg::REG_BOTH_SIDES:   cfg_in.both_sides   = pwdata[0];
            srsf_pkg::REG_ROW_COUNT:    cfg_in.row_count    = pwdata[srsf_pkg::COUNT_BITS-1:0];
            srsf_pkg::REG_COLUMN_COUNT: cfg_in.column_count = pwdata[srsf_pkg::COUNT_BITS-1:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         srsf_pkg::REG_SCALE_KIND:   prdata = 32'(cfg_ff.scale_kind);
         srsf_pkg::REG_BOTH_SIDES:   prdata = 32'(cfg_ff.both_sides);
         srsf_pkg::REG_ROW_COUNT:    prdata = 32'(cfg_ff.row_count);
         srsf_pkg::REG_COLUMN_COUNT: prdata = 32'(cfg_ff.column_count);
         default:                    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale_kind   <= srsf_pkg::KIND_NORM;
         cfg_ff.both_sides   <= 1'b0;
         cfg_ff.row_count    <= 17'd16;
         cfg_ff.column_count <= 17'd16;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   srsf_front #(
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .push         (push),
      .full         (full),
      .entry_value  (req_entry_value),
      .entry_column (req_entry_column),
      .has_entry    (req_has_entry),
      .row_end      (req_row_end),
      .q_push       (q_push),
      .q_job        (push_job),
      .q_full       (q_full)
   );

   srsf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .empty    (q_empty)
   );

   srsf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_job     (pop_job),
      .empty     (empty),
      .pop       (pop),
      .row_index (rsp_row_index),
      .factor    (rsp_factor),
      .status    (rsp_status),
      .last_row  (rsp_last_row)
   );

endmodule

// ----- verif/sparse_row_scale_factor_gen_core_test.sv -----
// Self-checking testbench of sparse_row_scale_factor_gen_core: random row streams, APB setup.
// Depends on srsf_pkg and the core; predicts each row factor and checks every response.
`timescale 1ns / 1ps

module sparse_row_scale_factor_gen_core_test;

   typedef struct packed {
      logic [31:0] value;
      logic [15:0] column;
      logic        has_entry;
      logic        row_end;
   } entry_type;

   typedef struct packed {
      logic [15:0] row_index;
      logic [31:0] factor;
      logic [2:0]  status;
      logic        last_row;
   } factor_type;

   localparam int CYCLE_LIMIT = 2000000;

   logic clock = 0, reset = 1;
   logic push = 0, full;
   logic [31:0] req_entry_value = 0;
   logic [15:0] req_entry_column = 0;
   logic req_has_entry = 0, req_row_end = 0;
   logic empty, pop = 0;
   logic [15:0] rsp_row_index;
   logic [31:0] rsp_factor;
   logic [2:0] rsp_status;
   logic rsp_last_row;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [3:0] paddr = 0;
   logic [31:0] pwdata = 0, prdata;
   logic pready;

   sparse_row_scale_factor_gen_core uut (.*);

   entry_type pending_entries[$];
   factor_type expected_factors[$];
   int errors = 0;
   int cycles = 0;
   bit quiet = 0;
   int push_gap = 0, pop_gap = 0;

   logic [1:0] kind_reg = srsf_pkg::KIND_NORM;
   logic both_reg = 0;
   logic [16:0] rows_reg = 17'd16, cols_reg = 17'd16;
   int row_pos = 0, gen_row = 0;
   logic [63:0] sum_acc = 0;
   logic [31:0] diag_acc = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("sparse_row_scale_factor_gen_core test failed");
         $finish;
      end
   end

   function automatic logic [63:0] int_sqrt(logic [63:0] op);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > op) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (op >= res + bitv) begin
            op = op - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [31:0] clamp_up(logic [63:0] q, ref logic [2:0] st);
      if (q > 64'h7FFF_FFFF) begin
         st = srsf_pkg::ST_SAT;
         return srsf_pkg::FX_MAXPOS;
      end
      return q[31:0];
   endfunction

   function automatic logic [31:0] scale_of_row(ref logic [2:0] st);
      logic neg;
      logic [63:0] d, q, s;
      s = sum_acc;
      neg = diag_acc[31];
      d = neg ? {32'd0, -diag_acc} : {32'd0, diag_acc};
      if (neg && diag_acc == 32'h8000_0000) d = 64'h8000_0000;
      st = srsf_pkg::ST_OK;
      if (kind_reg == srsf_pkg::KIND_NORM) begin
         if (s == 0) begin
            st = srsf_pkg::ST_ZERO;
            return srsf_pkg::FX_MAXPOS;
         end
         if (both_reg) return clamp_up((64'd1 << 48) / s, st);
         if (s == 1) begin
            st = srsf_pkg::ST_SAT;
            return srsf_pkg::FX_MAXPOS;
         end
         q = 64'hFFFF_FFFF_FFFF_FFFF / s + (((s & (s - 1)) == 0) ? 64'd1 : 64'd0);
         return clamp_up(int_sqrt(q), st);
      end
      if (d == 0) begin
         st = srsf_pkg::ST_ZERO;
         return srsf_pkg::FX_MAXPOS;
      end
      if (both_reg) begin
         if (neg) begin
            st = srsf_pkg::ST_NEG;
            return srsf_pkg::FX_ZERO;
         end
         return clamp_up(int_sqrt((64'd1 << 48) / d), st);
      end
      q = (64'd1 << 32) / d;
      if (!neg) return clamp_up(q, st);
      if (q > 64'h8000_0000) begin
         st = srsf_pkg::ST_SAT;
         q = 64'h8000_0000;
      end
      return 32'd0 - q[31:0];
   endfunction

   task automatic accumulate_entry(entry_type e);
      logic [63:0] mag, sq;
      factor_type r;
      logic [2:0] st;
      logic last;
      if (e.has_entry) begin
         mag = e.value[31] ? {32'd0, -e.value} : {32'd0, e.value};
         if (e.value == 32'h8000_0000) mag = 64'h8000_0000;
         sq = mag * mag;
         sum_acc = (sum_acc > ~sq) ? 64'hFFFF_FFFF_FFFF_FFFF : sum_acc + sq;
         if (e.column == row_pos[15:0]) diag_acc = e.value;
      end
      if (!e.row_end) return;
      if ((kind_reg != srsf_pkg::KIND_NORM && kind_reg != srsf_pkg::KIND_DIAG)
          || rows_reg != cols_reg) begin
         r.factor = srsf_pkg::FX_ONE;
         st = srsf_pkg::ST_NOSCALE;
      end else begin
         r.factor = scale_of_row(st);
      end
      last = (rows_reg != 0) && (row_pos + 1 == rows_reg);
      r.row_index = row_pos[15:0];
      r.status = st;
      r.last_row = last;
      expected_factors.push_back(r);
      row_pos = row_pos + 1;
      if (last || row_pos >= srsf_pkg::DEF_MAX_ROWS) row_pos = 0;
      sum_acc = 0;
      diag_acc = 0;
   endtask

   always @(posedge clock) begin
      if (push && !full) accumulate_entry({req_entry_value, req_entry_column,
                                           req_has_entry, req_row_end});
      if (!(push && full)) begin
         if (push_gap > 0) begin
            push_gap <= push_gap - 1;
            push <= 0;
         end else if (pending_entries.size() == 0) begin
            push <= 0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            push_gap <= $urandom_range(0, 7);
            push <= 0;
         end else begin
            entry_type e;
            e = pending_entries.pop_front();
            push <= 1;
            req_entry_value <= e.value;
            req_entry_column <= e.column;
            req_has_entry <= e.has_entry;
            req_row_end <= e.row_end;
         end
      end
   end

   always @(posedge clock) begin
      if (pop && !empty) begin
         if (expected_factors.size() == 0) begin
            $error("unexpected response row_index %0d", rsp_row_index);
            errors++;
         end else begin
            factor_type x;
            x = expected_factors.pop_front();
            if (rsp_row_index !== x.row_index) begin
               $error("row_index expected %0d actual %0d", x.row_index, rsp_row_index);
               errors++;
            end
            if (rsp_factor !== x.factor) begin
               $error("factor expected %h actual %h", x.factor, rsp_factor);
               errors++;
            end
            if (rsp_status !== x.status) begin
               $error("status expected %0d actual %0d", x.status, rsp_status);
               errors++;
            end
            if (rsp_last_row !== x.last_row) begin
               $error("last_row expected %0d actual %0d", x.last_row, rsp_last_row);
               errors++;
            end
         end
      end
      if (reset) begin
         pop <= 0;
      end else if (pop_gap > 0) begin
         pop_gap <= pop_gap - 1;
         pop <= 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         pop_gap <= $urandom_range(0, 7);
         pop <= 0;
      end else begin
         pop <= 1;
      end
   end

   task automatic write_reg(logic [1:0] index, logic [31:0] data);
      @(posedge clock);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {index, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
   endtask

   task automatic configure(logic [1:0] kind, logic both, logic [16:0] rows, logic [16:0] cols);
      write_reg(srsf_pkg::REG_SCALE_KIND, 32'(kind));
      write_reg(srsf_pkg::REG_BOTH_SIDES, 32'(both));
      write_reg(srsf_pkg::REG_ROW_COUNT, 32'(rows));
      write_reg(srsf_pkg::REG_COLUMN_COUNT, 32'(cols));
      kind_reg = kind;
      both_reg = both;
      rows_reg = rows;
      cols_reg = cols;
   endtask

   task automatic add_entry(logic [31:0] v, logic [15:0] c, logic h, logic e);
      pending_entries.push_back({v, c, h, e});
      if (e) begin
         gen_row = gen_row + 1;
         if ((rows_reg != 0 && gen_row == rows_reg) || gen_row >= srsf_pkg::DEF_MAX_ROWS)
            gen_row = 0;
      end
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 3);
         3: return 32'd0 - $urandom_range(1, 4);
         4: return $urandom_range(1, 255) << 16;
         5: return 32'd0 - ($urandom_range(1, 255) << 16);
         default: return $urandom;
      endcase
   endfunction

   task automatic add_random_rows(int count);
      int n, k;
      logic [15:0] c;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 19) == 0) add_entry($urandom, 16'($urandom), 1'b0, 1'b0);
         n = $urandom_range(0, 5);
         if (n == 0) begin
            add_entry($urandom, 16'($urandom), 1'b0, 1'b1);
         end else begin
            for (k = 0; k < n; k++) begin
               c = ($urandom_range(0, 2) == 0) ? 16'($urandom) : gen_row[15:0];
               add_entry(pick_value(), c, 1'b1, k == n - 1);
            end
         end
      end
   endtask

   task automatic drain();
      while (pending_entries.size() != 0 || push || expected_factors.size() != 0)
         @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      repeat (2) @(posedge clock);

      configure(srsf_pkg::KIND_NORM, 1'b0, 17'd16, 17'd16);
      add_entry(32'h0000_0001, 16'd0, 1'b1, 1'b1);
      add_entry(32'd0, 16'd0, 1'b0, 1'b1);
      add_entry(32'h8000_0000, 16'd2, 1'b1, 1'b0);
      add_entry(32'h8000_0000, 16'd2, 1'b1, 1'b0);
      add_entry(32'h7FFF_FFFF, 16'hFFFF, 1'b1, 1'b1);
      add_entry(32'h0001_0000, 16'd3, 1'b0, 1'b0);
      add_entry(32'h0001_0000, 16'd3, 1'b1, 1'b1);
      add_random_rows(70);
      drain();

      configure(srsf_pkg::KIND_DIAG, 1'b0, 17'd16, 17'd16);
      add_entry(32'hFFFF_0000, gen_row[15:0], 1'b1, 1'b1);
      add_entry(32'h0002_0000, 16'hFFFF, 1'b1, 1'b1);
      add_entry(32'h0002_0000, gen_row[15:0], 1'b1, 1'b0);
      add_entry(32'h0000_0001, gen_row[15:0], 1'b1, 1'b1);
      add_entry(32'h8000_0000, gen_row[15:0], 1'b1, 1'b1);
      add_entry(32'h0000_0001, gen_row[15:0], 1'b1, 1'b1);
      add_entry(32'hFFFF_FFFF, gen_row[15:0], 1'b1, 1'b1);
      add_random_rows(70);
      drain();

      configure(srsf_pkg::KIND_DIAG, 1'b1, 17'd5, 17'd5);
      add_entry(32'hFFFF_0000, gen_row[15:0], 1'b1, 1'b1);
      add_entry(32'h0000_0001, gen_row[15:0], 1'b1, 1'b1);
      add_random_rows(80);
      drain();

      configure(srsf_pkg::KIND_NORM, 1'b1, 17'd1, 17'd1);
      add_random_rows(80);
      drain();

      configure(srsf_pkg::KIND_NONE, 1'b0, 17'd7, 17'd7);
      add_random_rows(55);
      drain();

      configure(srsf_pkg::KIND_UNUSED, 1'b1, 17'd4, 17'd4);
      add_random_rows(40);
      drain();

      configure(srsf_pkg::KIND_DIAG, 1'b0, 17'd3, 17'd7);
      add_random_rows(40);
      drain();

      configure(srsf_pkg::KIND_NORM, 1'b0, 17'h10000, 17'h10000);
      add_random_rows(80);
      drain();

      configure(srsf_pkg::KIND_DIAG, 1'b1, 17'd9, 17'd9);
      add_random_rows(80);
      drain();

      quiet = 1;
      configure(srsf_pkg::KIND_NORM, 1'b1, 17'd6, 17'd6);
      add_random_rows(80);
      drain();

      if (errors == 0) begin
         $display("sparse_row_scale_factor_gen_core test passed");
      end else begin
         $display("sparse_row_scale_factor_gen_core test failed");
      end
      $finish;
   end

endmodule
